FILE: hw/rtl/clcd_pkg.sv
// clcd_pkg: shared types and constants of the character LCD expander driver.
// No dependencies.

package clcd_pkg;

    typedef enum logic [3:0] {
        OP_NIBBLE    = 4'd0,
        OP_CLEAR     = 4'd1,
        OP_HOME      = 4'd2,
        OP_MOVE      = 4'd3,
        OP_BACKLIGHT = 4'd4,
        OP_GLYPH_SEL = 4'd5,
        OP_GLYPH_ROW = 4'd6,
        OP_PUT_CHAR  = 4'd7,
        OP_CLEAR_EOL = 4'd8,
        OP_RAW_CMD   = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture accepted item
        logic exec;   // build one port byte group, update state
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;   // group in the output register closes the item
    } stat_t;

    localparam logic [1:0] CFG_LINE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [2:0] LINE_COUNT_RST   = 3'd2;
    localparam logic [5:0] COLUMN_COUNT_RST = 6'd16;

    localparam logic [7:0] PIN_RS = 8'h01;
    localparam logic [7:0] PIN_E  = 8'h04;

    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_HOME   = 8'h02;
    localparam logic [7:0] CMD_CGRAM  = 8'h40;
    localparam logic [7:0] CMD_DDRAM  = 8'h80;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [2:0] BYTES_NONE   = 3'd0;
    localparam logic [2:0] BYTES_ONE    = 3'd1;
    localparam logic [2:0] BYTES_NIBBLE = 3'd2;
    localparam logic [2:0] BYTES_FULL   = 3'd4;

    // DDRAM start address of a display row
    function automatic logic [7:0] row_start(input logic [1:0] row,
                                             input logic [2:0] lines,
                                             input logic [5:0] cols);
        logic [7:0] addr;
        addr = 8'h00;
        if (row == 2'd1) begin
            addr = 8'h40;
        end else if (row[1] && lines == 3'd4) begin
            if (cols == 6'd16) begin
                addr = row[0] ? 8'h50 : 8'h10;
            end else if (cols == 6'd20) begin
                addr = row[0] ? 8'h54 : 8'h14;
            end
        end
        return addr;
    endfunction

endpackage

FILE: hw/rtl/clcd_ctrl.sv
// clcd_ctrl: sequencing FSM for the character LCD expander driver.
// Depends on clcd_pkg.

module clcd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  clcd_pkg::stat_t stat,
    output clcd_pkg::cmd_t  cmd
);

    clcd_pkg::state_t state_reg;
    clcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clcd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clcd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = clcd_pkg::S_EXEC;
                end
            end
            clcd_pkg::S_EXEC:
            begin
                state_next = clcd_pkg::S_OUT;
            end
            clcd_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = stat.last ? clcd_pkg::S_IDLE : clcd_pkg::S_EXEC;
                end
            end
            default:
            begin
                state_next = clcd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            clcd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            clcd_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            clcd_pkg::S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/clcd_dp.sv
// clcd_dp: geometry registers, port shadow, cursor and result register.
// Depends on clcd_pkg.

module clcd_dp #(
    parameter int MAX_ROWS    = 4,
    parameter int MAX_COLUMNS = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  clcd_pkg::cmd_t  cmd,
    output clcd_pkg::stat_t stat,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [5:0]      cfg_data,
    input  logic [3:0]      op,
    input  logic [1:0]      row,
    input  logic [5:0]      col,
    input  logic [7:0]      data_byte,
    input  logic            backlight_on,
    input  logic [2:0]      glyph_index,
    output logic [2:0]      byte_count,
    output logic [7:0]      port_byte_0,
    output logic [7:0]      port_byte_1,
    output logic [7:0]      port_byte_2,
    output logic [7:0]      port_byte_3,
    output logic            last,
    output logic            rejected
);

    localparam logic [5:0] COL_MAX = 6'(MAX_COLUMNS);
    localparam logic [2:0] ROW_MAX = 3'(MAX_ROWS);

    // captured item
    logic [3:0] op_reg;
    logic [1:0] row_reg;
    logic [5:0] col_reg;
    logic [7:0] data_reg;
    logic       bl_reg;
    logic [2:0] glyph_reg;

    logic [2:0] line_count_reg;
    logic [5:0] column_count_reg;

    logic [7:0] shadow_reg, shadow_next;
    logic [5:0] cur_col_reg, cur_col_next;
    logic [1:0] cur_row_reg, cur_row_next;

    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic [7:0] b2_reg, b2_next;
    logic [7:0] b3_reg, b3_next;
    logic       last_reg, last_next;
    logic       rej_reg, rej_next;

    logic [5:0] col_lim;
    logic [2:0] row_lim;
    logic [5:0] cur_col_inc;
    logic [7:0] move_addr;
    logic       send_rs;
    logic [7:0] send_val;
    logic [7:0] rs_shadow;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
    logic [7:0] nib_byte;
    logic [7:0] bl_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg   <= clcd_pkg::LINE_COUNT_RST;
            column_count_reg <= clcd_pkg::COLUMN_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == clcd_pkg::CFG_LINE_COUNT)
            begin
                line_count_reg <= cfg_data[2:0];
            end
            else if (cfg_index == clcd_pkg::CFG_COLUMN_COUNT)
            begin
                column_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            row_reg   <= row;
            col_reg   <= col;
            data_reg  <= data_byte;
            bl_reg    <= backlight_on;
            glyph_reg <= glyph_index;
        end
    end

    assign col_lim     = (column_count_reg > COL_MAX) ? COL_MAX : column_count_reg;
    assign row_lim     = (line_count_reg > ROW_MAX) ? ROW_MAX : line_count_reg;
    assign cur_col_inc = 6'(cur_col_reg + 6'd1);
    assign move_addr   = 8'(clcd_pkg::row_start(row_reg, line_count_reg, column_count_reg)
                         + {2'b00, col_reg}) | clcd_pkg::CMD_DDRAM;

    // byte to send and its RS level
    always_comb
    begin
        send_rs  = 1'b1;
        send_val = data_reg;
        unique case (clcd_pkg::op_t'(op_reg))
            clcd_pkg::OP_CLEAR:     begin send_rs = 1'b0; send_val = clcd_pkg::CMD_CLEAR; end
            clcd_pkg::OP_HOME:      begin send_rs = 1'b0; send_val = clcd_pkg::CMD_HOME; end
            clcd_pkg::OP_MOVE:      begin send_rs = 1'b0; send_val = move_addr; end
            clcd_pkg::OP_GLYPH_SEL:
            begin
                send_rs  = 1'b0;
                send_val = clcd_pkg::CMD_CGRAM | {2'b00, glyph_reg, 3'b000};
            end
            clcd_pkg::OP_RAW_CMD:   begin send_rs = 1'b0; send_val = data_reg; end
            clcd_pkg::OP_CLEAR_EOL: begin send_rs = 1'b1; send_val = clcd_pkg::CHAR_SPACE; end
            default:                begin send_rs = 1'b1; send_val = data_reg; end
        endcase
    end

    assign rs_shadow = {shadow_reg[7:1], send_rs};
    assign hi_byte   = {send_val[7:4], rs_shadow[3:0]};
    assign lo_byte   = {send_val[3:0], rs_shadow[3:0]};
    assign nib_byte  = {data_reg[7:4], shadow_reg[3:0]};
    assign bl_byte   = {shadow_reg[7:4], bl_reg, shadow_reg[2:0]};

    always_comb
    begin
        shadow_next  = shadow_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        cnt_next     = clcd_pkg::BYTES_FULL;
        b0_next      = hi_byte | clcd_pkg::PIN_E;
        b1_next      = hi_byte;
        b2_next      = lo_byte | clcd_pkg::PIN_E;
        b3_next      = lo_byte;
        last_next    = 1'b1;
        rej_next     = 1'b0;
        unique case (clcd_pkg::op_t'(op_reg))
            clcd_pkg::OP_NIBBLE:
            begin
                shadow_next = nib_byte;
                cnt_next    = clcd_pkg::BYTES_NIBBLE;
                b0_next     = nib_byte | clcd_pkg::PIN_E;
                b1_next     = nib_byte;
                b2_next     = 8'h00;
                b3_next     = 8'h00;
            end
            clcd_pkg::OP_CLEAR, clcd_pkg::OP_HOME:
            begin
                shadow_next  = lo_byte;
                cur_col_next = 6'd0;
                cur_row_next = 2'd0;
            end
            clcd_pkg::OP_MOVE:
            begin
                if ({1'b0, row_reg} < row_lim && col_reg < col_lim)
                begin
                    shadow_next  = lo_byte;
                    cur_col_next = col_reg;
                    cur_row_next = row_reg;
                end
                else
                begin
                    cnt_next = clcd_pkg::BYTES_NONE;
                    rej_next = 1'b1;
                end
            end
            clcd_pkg::OP_BACKLIGHT:
            begin
                shadow_next = bl_byte;
                cnt_next    = clcd_pkg::BYTES_ONE;
                b0_next     = bl_byte;
                b1_next     = 8'h00;
                b2_next     = 8'h00;
                b3_next     = 8'h00;
            end
            clcd_pkg::OP_GLYPH_SEL, clcd_pkg::OP_GLYPH_ROW, clcd_pkg::OP_RAW_CMD:
            begin
                shadow_next = lo_byte;
            end
            clcd_pkg::OP_PUT_CHAR:
            begin
                if (cur_col_reg < col_lim)
                begin
                    shadow_next  = lo_byte;
                    cur_col_next = cur_col_inc;
                end
                else
                begin
                    cnt_next = clcd_pkg::BYTES_NONE;
                    rej_next = 1'b1;
                end
            end
            clcd_pkg::OP_CLEAR_EOL:
            begin
                // one space per pass; loop ends when the cursor hits the limit
                if (cur_col_reg < col_lim)
                begin
                    shadow_next  = lo_byte;
                    cur_col_next = cur_col_inc;
                    last_next    = !(cur_col_inc < col_lim);
                end
                else
                begin
                    cnt_next = clcd_pkg::BYTES_NONE;
                end
            end
            default:
            begin
                cnt_next = clcd_pkg::BYTES_NONE;
            end
        endcase
        if (cnt_next == clcd_pkg::BYTES_NONE)
        begin
            b0_next = 8'h00;
            b1_next = 8'h00;
            b2_next = 8'h00;
            b3_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg  <= 8'h00;
            cur_col_reg <= 6'd0;
            cur_row_reg <= 2'd0;
        end
        else if (cmd.exec)
        begin
            shadow_reg  <= shadow_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            cnt_reg  <= cnt_next;
            b0_reg   <= b0_next;
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
            b3_reg   <= b3_next;
            last_reg <= last_next;
            rej_reg  <= rej_next;
        end
    end

    assign stat.last   = last_reg;
    assign byte_count  = cnt_reg;
    assign port_byte_0 = b0_reg;
    assign port_byte_1 = b1_reg;
    assign port_byte_2 = b2_reg;
    assign port_byte_3 = b3_reg;
    assign last        = last_reg;
    assign rejected    = rej_reg;

endmodule

FILE: hw/rtl/char_lcd_expander_nibble_driver_top.sv
// Top level of the character LCD driver feeding an I2C port expander (4-bit mode).
// Each item is captured in idle, each group is built in the exec state and registered,
// then presented in the out state until taken; no new item is accepted until the
// last group of the item is taken, and clear to end of line builds one group per pass.
// Reset (rst_n, async low): 2 lines, 16 columns, port shadow and cursor zero.
// Depends on clcd_pkg, clcd_ctrl, clcd_dp.

module char_lcd_expander_nibble_driver_top #(
    parameter int MAX_ROWS    = 4,   // 1..4, caps line_count
    parameter int MAX_COLUMNS = 40   // 8..40, caps column_count
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    // request items
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [1:0] row,
    input  logic [5:0] col,
    input  logic [7:0] data_byte,
    input  logic       backlight_on,
    input  logic [2:0] glyph_index,
    // port byte group items
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] byte_count,
    output logic [7:0] port_byte_0,
    output logic [7:0] port_byte_1,
    output logic [7:0] port_byte_2,
    output logic [7:0] port_byte_3,
    output logic       last,
    output logic       rejected
);

    // Controller walks idle -> build -> present; clear to end of line
    // returns to build until the cursor reaches the column limit.
    clcd_pkg::cmd_t  cmd;
    clcd_pkg::stat_t stat;

    clcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath holds the geometry, the port shadow (data nibble, BL, E, RW,
    // RS) and the cursor, and registers each group for the output side.
    clcd_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .row          (row),
        .col          (col),
        .data_byte    (data_byte),
        .backlight_on (backlight_on),
        .glyph_index  (glyph_index),
        .byte_count   (byte_count),
        .port_byte_0  (port_byte_0),
        .port_byte_1  (port_byte_1),
        .port_byte_2  (port_byte_2),
        .port_byte_3  (port_byte_3),
        .last         (last),
        .rejected     (rejected)
    );

endmodule

FILE: hw/rtl/clcd_checker.sv
// clcd_checker: port-level assertions for the character LCD expander driver.
// Bound to char_lcd_expander_nibble_driver_top; no other dependencies.

module clcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] byte_count,
    input logic [7:0] port_byte_0,
    input logic [7:0] port_byte_1,
    input logic [7:0] port_byte_2,
    input logic [7:0] port_byte_3,
    input logic       last,
    input logic       rejected
);

    // stalled item holds its byte count, last flag and first two port bytes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(port_byte_0)
            && $stable(port_byte_1) && $stable(byte_count) && $stable(last))
        else $error("output item changed while stalled");

    // groups are empty, backlight, nibble or full byte
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count == 3'd0 || byte_count == 3'd1
            || byte_count == 3'd2 || byte_count == 3'd4)
        else $error("bad byte count");

    // a rejection sends nothing and closes the item
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> byte_count == 3'd0 && last)
        else $error("rejected item with bytes or not last");

    // one item at a time: no new item while a group is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("item accepted while busy");

endmodule

bind char_lcd_expander_nibble_driver_top clcd_checker u_clcd_checker (.*);
